@@ hdl/hlip_pkg.sv @@
package hlip_pkg;

	// default number of entries per list
	localparam int LIST_DEPTH_DEF = 256;

	// field widths
	localparam int CMD_W    = 4;
	localparam int VALUE_W  = 32;
	localparam int BYTES_W  = 3;
	localparam int PAGE_W   = 16;
	localparam int USAGE_W  = 16;
	localparam int SLOT_W   = 8;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 96;
	localparam int M_USER_W = 3;

	// byte count that marks an extended usage with its own page
	localparam logic [BYTES_W-1:0] EXT_USAGE_BYTES = 3'd4;

	// local item tags
	typedef enum logic [CMD_W-1:0] {
		TAG_USAGE   = 4'd0,
		TAG_UMIN    = 4'd1,
		TAG_UMAX    = 4'd2,
		TAG_DESIG   = 4'd3,
		TAG_DMIN    = 4'd4,
		TAG_DMAX    = 4'd5,
		TAG_STRING  = 4'd7,
		TAG_SMIN    = 4'd8,
		TAG_SMAX    = 4'd9,
		TAG_DELIM   = 4'd10
	} tag_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_PAGE   = 2'd1,
		ST_INVERT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// emitted entry kinds
	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_USAGE  = 2'd1,
		KIND_DESIG  = 2'd2,
		KIND_STRING = 2'd3
	} kind_t;

	// one result item
	typedef struct packed {
		logic [VALUE_W-1:0] last;
		logic [VALUE_W-1:0] first;
		logic [PAGE_W-1:0]  page;
		logic [SLOT_W-1:0]  slot;
		logic               is_range;
		kind_t              kind;
		status_t            status;
	} result_t;

endpackage

@@ hdl/hid_local_item_pairing_core.sv @@
// HID local item pairing core
//
// Input channel s_axis: one decoded local item per handshake. s_axis_tuser holds
// the tag, s_axis_tdata holds value, byte count and current usage page.
// Output channel m_axis: exactly one result item per input item, in order.
// m_axis_tuser holds entry kind and range flag, m_axis_tdata holds status,
// slot, page, first and last.
//
// The input handshake loads the input register; the pairing result then moves
// into the output register when the output stage can advance, raising
// m_axis_tvalid. Sustained throughput is one item per cycle while m_axis_tready
// stays high; the pending-bound and counter registers are updated in the same
// cycle the item enters the output register, so the next item sees them at once.
//
// Reset clears all pending bits, held bounds and per-list counters and empties
// both pipeline stages. When m_axis_tready is low, the output register holds
// its item and the input stage fills; s_axis_tready drops only once both are
// occupied.
module hid_local_item_pairing_core #(
	parameter int LIST_DEPTH = hlip_pkg::LIST_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// item_value[31:0], data_bytes[34:32], current_page[50:35], zero[55:51]
	input  logic [hlip_pkg::S_DATA_W-1:0] s_axis_tdata,
	// cmd[3:0]
	input  logic [hlip_pkg::CMD_W-1:0]    s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// status[1:0], entry_slot[9:2], entry_page[25:10], entry_first[57:26],
	// entry_last[89:58], zero[95:90]
	output logic [hlip_pkg::M_DATA_W-1:0] m_axis_tdata,
	// entry_kind[1:0], is_range[2]
	output logic [hlip_pkg::M_USER_W-1:0] m_axis_tuser
);

	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

	// input stage
	logic                           valid_s1;
	logic [hlip_pkg::CMD_W-1:0]     cmd_s1;
	logic [hlip_pkg::VALUE_W-1:0]   value_s1;
	logic [hlip_pkg::BYTES_W-1:0]   bytes_s1;
	logic [hlip_pkg::PAGE_W-1:0]    cur_page_s1;

	// pairing state
	logic                           umin_p_q, umax_p_q;
	logic [hlip_pkg::PAGE_W-1:0]    range_page_q;
	logic [hlip_pkg::USAGE_W-1:0]   umin_q, umax_q;
	logic                           dmin_p_q, dmax_p_q;
	logic [hlip_pkg::VALUE_W-1:0]   dmin_q, dmax_q;
	logic                           smin_p_q, smax_p_q;
	logic [hlip_pkg::VALUE_W-1:0]   smin_q, smax_q;
	logic [CW-1:0]                  ucnt_q, dcnt_q, scnt_q;

	// next state
	logic                           umin_p_d, umax_p_d;
	logic [hlip_pkg::PAGE_W-1:0]    range_page_d;
	logic [hlip_pkg::USAGE_W-1:0]   umin_d, umax_d;
	logic                           dmin_p_d, dmax_p_d;
	logic [hlip_pkg::VALUE_W-1:0]   dmin_d, dmax_d;
	logic                           smin_p_d, smax_p_d;
	logic [hlip_pkg::VALUE_W-1:0]   smin_d, smax_d;
	logic [CW-1:0]                  ucnt_d, dcnt_d, scnt_d;

	// output stage
	logic                           m_valid_q;
	hlip_pkg::result_t              res_q;
	hlip_pkg::result_t              res_d;

	logic                           adv;
	logic                           step;
	logic [hlip_pkg::PAGE_W-1:0]    upage;
	logic [hlip_pkg::USAGE_W-1:0]   uval;
	logic [hlip_pkg::USAGE_W-1:0]   ulo, uhi;
	logic [hlip_pkg::VALUE_W-1:0]   ilo, ihi;
	logic                           is_max;

	// handshake
	assign adv           = !m_valid_q || m_axis_tready;
	assign step          = adv && valid_s1;
	assign s_axis_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1      <= s_axis_tuser;
			value_s1    <= s_axis_tdata[31:0];
			bytes_s1    <= s_axis_tdata[34:32];
			cur_page_s1 <= s_axis_tdata[50:35];
		end
	end

	// usage page and value of the item in stage one
	assign upage = (bytes_s1 == hlip_pkg::EXT_USAGE_BYTES) ? value_s1[31:16] : cur_page_s1;
	assign uval  = value_s1[15:0];

	// pairing logic
	always_comb begin
		umin_p_d     = umin_p_q;
		umax_p_d     = umax_p_q;
		range_page_d = range_page_q;
		umin_d       = umin_q;
		umax_d       = umax_q;
		dmin_p_d     = dmin_p_q;
		dmax_p_d     = dmax_p_q;
		dmin_d       = dmin_q;
		dmax_d       = dmax_q;
		smin_p_d     = smin_p_q;
		smax_p_d     = smax_p_q;
		smin_d       = smin_q;
		smax_d       = smax_q;
		ucnt_d       = ucnt_q;
		dcnt_d       = dcnt_q;
		scnt_d       = scnt_q;
		res_d        = '0;
		is_max       = 1'b0;
		ulo          = '0;
		uhi          = '0;
		ilo          = '0;
		ihi          = '0;

		unique case (hlip_pkg::tag_t'(cmd_s1)) inside
			hlip_pkg::TAG_USAGE: begin
				if (ucnt_q >= DEPTH_C) begin
					res_d.status = hlip_pkg::ST_FULL;
				end else begin
					res_d.kind  = hlip_pkg::KIND_USAGE;
					res_d.slot  = hlip_pkg::SLOT_W'(ucnt_q);
					res_d.page  = upage;
					res_d.first = {16'd0, uval};
					ucnt_d      = ucnt_q + CW'(1);
				end
			end
			hlip_pkg::TAG_UMIN, hlip_pkg::TAG_UMAX: begin
				is_max = (cmd_s1 == hlip_pkg::TAG_UMAX);
				ulo    = is_max ? umin_q : uval;
				uhi    = is_max ? uval : umax_q;
				// partner not pending: hold this bound
				if (!(is_max ? umin_p_q : umax_p_q)) begin
					range_page_d = upage;
					if (is_max) begin
						umax_d   = uval;
						umax_p_d = 1'b1;
					end else begin
						umin_d   = uval;
						umin_p_d = 1'b1;
					end
				end else if (upage != range_page_q) begin
					res_d.status = hlip_pkg::ST_PAGE;
				end else if (uhi < ulo) begin
					res_d.status = hlip_pkg::ST_INVERT;
				end else if (ucnt_q >= DEPTH_C) begin
					res_d.status = hlip_pkg::ST_FULL;
				end else begin
					res_d.kind     = hlip_pkg::KIND_USAGE;
					res_d.is_range = 1'b1;
					res_d.slot     = hlip_pkg::SLOT_W'(ucnt_q);
					res_d.page     = upage;
					res_d.first    = {16'd0, ulo};
					res_d.last     = {16'd0, uhi};
					ucnt_d         = ucnt_q + CW'(1);
					umin_p_d       = 1'b0;
					umax_p_d       = 1'b0;
				end
			end
			hlip_pkg::TAG_DESIG: begin
				if (dcnt_q >= DEPTH_C) begin
					res_d.status = hlip_pkg::ST_FULL;
				end else begin
					res_d.kind  = hlip_pkg::KIND_DESIG;
					res_d.slot  = hlip_pkg::SLOT_W'(dcnt_q);
					res_d.first = value_s1;
					dcnt_d      = dcnt_q + CW'(1);
				end
			end
			hlip_pkg::TAG_DMIN, hlip_pkg::TAG_DMAX: begin
				is_max = (cmd_s1 == hlip_pkg::TAG_DMAX);
				ilo    = is_max ? dmin_q : value_s1;
				ihi    = is_max ? value_s1 : dmax_q;
				if (!(is_max ? dmin_p_q : dmax_p_q)) begin
					if (is_max) begin
						dmax_d   = value_s1;
						dmax_p_d = 1'b1;
					end else begin
						dmin_d   = value_s1;
						dmin_p_d = 1'b1;
					end
				end else if (dcnt_q >= DEPTH_C) begin
					res_d.status = hlip_pkg::ST_FULL;
				end else begin
					res_d.kind     = hlip_pkg::KIND_DESIG;
					res_d.is_range = 1'b1;
					res_d.slot     = hlip_pkg::SLOT_W'(dcnt_q);
					res_d.first    = ilo;
					res_d.last     = ihi;
					dcnt_d         = dcnt_q + CW'(1);
					dmin_p_d       = 1'b0;
					dmax_p_d       = 1'b0;
				end
			end
			hlip_pkg::TAG_STRING: begin
				if (scnt_q >= DEPTH_C) begin
					res_d.status = hlip_pkg::ST_FULL;
				end else begin
					res_d.kind  = hlip_pkg::KIND_STRING;
					res_d.slot  = hlip_pkg::SLOT_W'(scnt_q);
					res_d.first = value_s1;
					scnt_d      = scnt_q + CW'(1);
				end
			end
			hlip_pkg::TAG_SMIN, hlip_pkg::TAG_SMAX: begin
				is_max = (cmd_s1 == hlip_pkg::TAG_SMAX);
				ilo    = is_max ? smin_q : value_s1;
				ihi    = is_max ? value_s1 : smax_q;
				if (!(is_max ? smin_p_q : smax_p_q)) begin
					if (is_max) begin
						smax_d   = value_s1;
						smax_p_d = 1'b1;
					end else begin
						smin_d   = value_s1;
						smin_p_d = 1'b1;
					end
				end else if (scnt_q >= DEPTH_C) begin
					res_d.status = hlip_pkg::ST_FULL;
				end else begin
					res_d.kind     = hlip_pkg::KIND_STRING;
					res_d.is_range = 1'b1;
					res_d.slot     = hlip_pkg::SLOT_W'(scnt_q);
					res_d.first    = ilo;
					res_d.last     = ihi;
					scnt_d         = scnt_q + CW'(1);
					smin_p_d       = 1'b0;
					smax_p_d       = 1'b0;
				end
			end
			// delimiter and unused tags pass with nothing emitted
			default: begin
			end
		endcase
	end

	// pairing state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			umin_p_q     <= 1'b0;
			umax_p_q     <= 1'b0;
			range_page_q <= '0;
			umin_q       <= '0;
			umax_q       <= '0;
			dmin_p_q     <= 1'b0;
			dmax_p_q     <= 1'b0;
			dmin_q       <= '0;
			dmax_q       <= '0;
			smin_p_q     <= 1'b0;
			smax_p_q     <= 1'b0;
			smin_q       <= '0;
			smax_q       <= '0;
			ucnt_q       <= '0;
			dcnt_q       <= '0;
			scnt_q       <= '0;
		end else if (step) begin
			umin_p_q     <= umin_p_d;
			umax_p_q     <= umax_p_d;
			range_page_q <= range_page_d;
			umin_q       <= umin_d;
			umax_q       <= umax_d;
			dmin_p_q     <= dmin_p_d;
			dmax_p_q     <= dmax_p_d;
			dmin_q       <= dmin_d;
			dmax_q       <= dmax_d;
			smin_p_q     <= smin_p_d;
			smax_p_q     <= smax_p_d;
			smin_q       <= smin_d;
			smax_q       <= smax_d;
			ucnt_q       <= ucnt_d;
			dcnt_q       <= dcnt_d;
			scnt_q       <= scnt_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	// port packing
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, res_q.last, res_q.first, res_q.page, res_q.slot,
		res_q.status};
	assign m_axis_tuser  = {res_q.is_range, res_q.kind};

endmodule

@@ hdl/hlip_checker.sv @@
module hlip_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [hlip_pkg::S_DATA_W-1:0] s_axis_tdata,
	input logic [hlip_pkg::CMD_W-1:0]    s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [hlip_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic [hlip_pkg::M_USER_W-1:0] m_axis_tuser
);

	// stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output item changed while stalled");

	// an error status never comes with an emitted entry
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] != hlip_pkg::ST_OK) |->
		(m_axis_tuser == '0) && (m_axis_tdata[89:2] == '0))
		else $error("error status with nonzero entry fields");

	// a single entry has no range maximum
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[89:58] == '0)
		else $error("single entry with nonzero last");

	// only usage entries carry a page
	a_page_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] != hlip_pkg::KIND_USAGE) |->
		m_axis_tdata[25:10] == '0)
		else $error("page on a non-usage entry");

	// input stalls only while an output item is waiting
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no output item waiting");

endmodule

bind hid_local_item_pairing_core hlip_checker u_hlip_checker (.*);

@@ tb/tb_hid_local_item_pairing_core.sv @@
module tb_hid_local_item_pairing_core;
	import hlip_pkg::*;

	localparam int DEPTH       = LIST_DEPTH_DEF;
	localparam int TOTAL_ITEMS = 650;
	localparam int IDLE_LIMIT  = 1000;
	localparam int MAX_PRINTS  = 40;

	// tags with no meaning, the block must pass them through as no-ops
	localparam logic [CMD_W-1:0] TAG_UNUSED_LO = 4'd6;
	localparam logic [CMD_W-1:0] TAG_UNUSED_HI = 4'd15;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [VALUE_W-1:0] value;
		logic [BYTES_W-1:0] nbytes;
		logic [PAGE_W-1:0]  page;
	} stim_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata  = '0;
	logic [CMD_W-1:0]    s_axis_tuser  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic [M_USER_W-1:0] m_axis_tuser;

	stim_t   pending_items [$];
	result_t expected_entries [$];
	logic    send_hold = 1'b0;
	int      n_pushed  = 0;
	int      err_count = 0;

	// shadow copy of the pairing state
	logic               umin_p = 1'b0, umax_p = 1'b0;
	logic [PAGE_W-1:0]  range_page = '0;
	logic [USAGE_W-1:0] h_umin = '0, h_umax = '0;
	logic               idx_min_p [2] = '{1'b0, 1'b0};
	logic               idx_max_p [2] = '{1'b0, 1'b0};
	logic [VALUE_W-1:0] idx_hmin [2] = '{'0, '0};
	logic [VALUE_W-1:0] idx_hmax [2] = '{'0, '0};
	int unsigned        entry_count [4] = '{0, 0, 0, 0};

	hid_local_item_pairing_core #(
		.LIST_DEPTH(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// append one entry to a list, or flag the list as full
	function automatic result_t emit_entry(kind_t k, logic rng, logic [PAGE_W-1:0] pg,
			logic [VALUE_W-1:0] first, logic [VALUE_W-1:0] last);
		result_t r;
		r = '0;
		if (entry_count[k] >= DEPTH) begin
			r.status = ST_FULL;
		end else begin
			r.status   = ST_OK;
			r.kind     = k;
			r.is_range = rng;
			r.slot     = SLOT_W'(entry_count[k]);
			r.page     = pg;
			r.first    = first;
			r.last     = last;
			entry_count[k]++;
		end
		return r;
	endfunction

	// expected result of one local item, updates the shadow state
	function automatic result_t pair_local_item(stim_t it);
		result_t            r;
		logic [PAGE_W-1:0]  upage;
		logic [USAGE_W-1:0] uval, ulo, uhi;
		logic               is_max;
		int                 li;
		kind_t              k;
		r     = '0;
		upage = (it.nbytes == EXT_USAGE_BYTES) ? it.value[31:16] : it.page;
		uval  = it.value[15:0];
		case (it.cmd)
			TAG_USAGE: r = emit_entry(KIND_USAGE, 1'b0, upage, VALUE_W'(uval), '0);
			TAG_DESIG: r = emit_entry(KIND_DESIG, 1'b0, '0, it.value, '0);
			TAG_STRING: r = emit_entry(KIND_STRING, 1'b0, '0, it.value, '0);
			TAG_UMIN, TAG_UMAX: begin
				is_max = (it.cmd == TAG_UMAX);
				if (!(is_max ? umin_p : umax_p)) begin
					// first bound, or a repeat that replaces the held one
					range_page = upage;
					if (is_max) begin
						h_umax = uval;
						umax_p = 1'b1;
					end else begin
						h_umin = uval;
						umin_p = 1'b1;
					end
				end else if (upage != range_page) begin
					r.status = ST_PAGE;
				end else begin
					ulo = is_max ? h_umin : uval;
					uhi = is_max ? uval : h_umax;
					if (uhi < ulo) begin
						r.status = ST_INVERT;
					end else begin
						r = emit_entry(KIND_USAGE, 1'b1, upage, VALUE_W'(ulo), VALUE_W'(uhi));
						if (r.status == ST_OK) begin
							umin_p = 1'b0;
							umax_p = 1'b0;
						end
					end
				end
			end
			TAG_DMIN, TAG_DMAX, TAG_SMIN, TAG_SMAX: begin
				li     = (it.cmd == TAG_DMIN || it.cmd == TAG_DMAX) ? 0 : 1;
				k      = (li == 0) ? KIND_DESIG : KIND_STRING;
				is_max = (it.cmd == TAG_DMAX || it.cmd == TAG_SMAX);
				if (!(is_max ? idx_min_p[li] : idx_max_p[li])) begin
					if (is_max) begin
						idx_hmax[li]  = it.value;
						idx_max_p[li] = 1'b1;
					end else begin
						idx_hmin[li]  = it.value;
						idx_min_p[li] = 1'b1;
					end
				end else begin
					// index ranges are never checked for inversion
					r = emit_entry(k, 1'b1, '0, is_max ? idx_hmin[li] : it.value,
						is_max ? it.value : idx_hmax[li]);
					if (r.status == ST_OK) begin
						idx_min_p[li] = 1'b0;
						idx_max_p[li] = 1'b0;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void push_item(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
			logic [BYTES_W-1:0] nb, logic [PAGE_W-1:0] pg);
		stim_t it;
		it.cmd    = cmd;
		it.value  = value;
		it.nbytes = nb;
		it.page   = pg;
		pending_items.push_back(it);
		n_pushed++;
	endfunction

	// the page rides either in the value or on current_page
	function automatic void push_usage_bound(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] pg,
			logic [USAGE_W-1:0] u);
		logic [BYTES_W-1:0] nb;
		nb = ($urandom_range(0, 2) == 0) ? EXT_USAGE_BYTES : BYTES_W'($urandom_range(0, 7));
		if (nb == EXT_USAGE_BYTES)
			push_item(cmd, {pg, u}, nb, PAGE_W'($urandom));
		else
			push_item(cmd, {USAGE_W'($urandom), u}, nb, pg);
	endfunction

	function automatic void push_usage_pair(logic [PAGE_W-1:0] pg, logic [USAGE_W-1:0] lo,
			logic [USAGE_W-1:0] hi);
		if ($urandom_range(0, 1) == 0) begin
			push_usage_bound(TAG_UMIN, pg, lo);
			push_usage_bound(TAG_UMAX, pg, hi);
		end else begin
			push_usage_bound(TAG_UMAX, pg, hi);
			push_usage_bound(TAG_UMIN, pg, lo);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_count < MAX_PRINTS)
			$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		err_count++;
	endtask

	// stop offering new items until every result is back
	task automatic drain_results();
		send_hold <= 1'b1;
		do @(posedge clk); while (s_axis_tvalid || expected_entries.size() != 0);
		send_hold <= 1'b0;
	endtask

	// sender: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left   = 0;
	always @(posedge clk) begin
		stim_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_items.size() != 0 && !send_hold) begin
				nxt = pending_items.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= nxt.cmd;
				s_axis_tdata  <= S_DATA_W'({nxt.page, nxt.nbytes, nxt.value});
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern is redrawn periodically, plus two long hold-offs
	int unsigned rx_cycle     = 0;
	int          rx_mode      = 0;
	int          rx_hold_left = 0;
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 32 == 0)
			rx_mode = $urandom_range(0, 3);
		if (rx_cycle == 300 || rx_cycle == 2000)
			rx_hold_left = 80;
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 2) == 0);
				default: m_axis_tready <= rx_cycle[1];
			endcase
		end
	end

	// predict on each accepted item, then check each accepted result
	always @(posedge clk) begin
		stim_t       it;
		result_t     want;
		logic [31:0] got_f [7];
		logic [31:0] want_f [7];
		string       names [7];
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				it.cmd    = s_axis_tuser;
				it.value  = s_axis_tdata[31:0];
				it.nbytes = s_axis_tdata[34:32];
				it.page   = s_axis_tdata[50:35];
				expected_entries.push_back(pair_local_item(it));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_entries.size() == 0) begin
					report_mismatch("result with no item pending", m_axis_tdata[31:0], '0);
				end else begin
					want  = expected_entries.pop_front();
					names = '{"status", "entry_kind", "is_range", "entry_slot", "entry_page",
						"entry_first", "entry_last"};
					got_f = '{32'(m_axis_tdata[1:0]), 32'(m_axis_tuser[1:0]),
						32'(m_axis_tuser[2]), 32'(m_axis_tdata[9:2]), 32'(m_axis_tdata[25:10]),
						m_axis_tdata[57:26], m_axis_tdata[89:58]};
					want_f = '{32'(want.status), 32'(want.kind), 32'(want.is_range),
						32'(want.slot), 32'(want.page), want.first, want.last};
					for (int i = 0; i < 7; i++)
						if (got_f[i] !== want_f[i])
							report_mismatch(names[i], got_f[i], want_f[i]);
				end
			end
		end
	end

	// watchdog on cycles with no traffic on either side
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int                 choice;
		int                 lst;
		logic               paused_once;
		logic [PAGE_W-1:0]  pg;
		logic [USAGE_W-1:0] lo, hi;
		logic [VALUE_W-1:0] v1, v2;
		tag_t               tmin, tmax, tone;
		paused_once = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// extremes of the fields and the usage page sources
		push_item(TAG_USAGE, 32'hFFFF_FFFF, EXT_USAGE_BYTES, 16'h0000);
		push_item(TAG_USAGE, 32'h0000_0000, 3'd0, 16'h0000);
		push_item(TAG_USAGE, 32'hABCD_1234, 3'd7, 16'hFFFF);
		// well-formed ranges in both orders, page by value or by current page
		push_item(TAG_UMIN, 32'h0000_0010, 3'd1, 16'h0001);
		push_item(TAG_UMAX, 32'h0001_0020, EXT_USAGE_BYTES, 16'h0002);
		push_item(TAG_UMAX, 32'h0009_FFFF, EXT_USAGE_BYTES, 16'h0000);
		push_item(TAG_UMIN, 32'h0009_0000, EXT_USAGE_BYTES, 16'h0000);
		// page mismatch, then the right partner
		push_item(TAG_UMIN, 32'h0000_0005, 3'd2, 16'h0002);
		push_item(TAG_UMAX, 32'h0000_0006, 3'd2, 16'h0003);
		push_item(TAG_UMAX, 32'h0000_0006, 3'd2, 16'h0002);
		// inverted range, then an equal-bound range
		push_item(TAG_UMIN, 32'h0000_0050, 3'd1, 16'h0004);
		push_item(TAG_UMAX, 32'h0000_0040, 3'd1, 16'h0004);
		push_item(TAG_UMAX, 32'hFFFF_0050, 3'd1, 16'h0004);
		// repeated minimum replaces value and page
		push_item(TAG_UMIN, 32'h0000_0001, 3'd1, 16'h0005);
		push_item(TAG_UMIN, 32'h0000_0002, 3'd1, 16'h0006);
		push_item(TAG_UMAX, 32'h0000_0003, 3'd1, 16'h0006);
		// designator and string lists, index ranges may be inverted
		push_item(TAG_DESIG, 32'hFFFF_FFFF, EXT_USAGE_BYTES, 16'hFFFF);
		push_item(TAG_DMIN, 32'hFFFF_FFFF, EXT_USAGE_BYTES, 16'h0000);
		push_item(TAG_DMAX, 32'h0000_0000, 3'd0, 16'h0000);
		push_item(TAG_STRING, 32'h0000_0000, 3'd0, 16'h0000);
		push_item(TAG_SMAX, 32'h0000_0007, 3'd1, 16'h0000);
		push_item(TAG_SMIN, 32'h0000_0009, 3'd1, 16'h0000);
		// delimiter and unused tags
		push_item(TAG_DELIM, $urandom, 3'd4, 16'hFFFF);
		push_item(TAG_UNUSED_LO, $urandom, 3'd1, 16'h1234);
		push_item(TAG_UNUSED_HI, 32'hFFFF_FFFF, 3'd7, 16'hFFFF);
		while (pending_items.size() != 0) @(posedge clk);
		drain_results();

		// random part
		while (n_pushed < TOTAL_ITEMS) begin
			choice = $urandom_range(0, 99);
			lst    = $urandom_range(1, 3);
			repeat (3)
				if (entry_count[lst] >= DEPTH && $urandom_range(0, 9) != 0)
					lst = $urandom_range(1, 3);
			pg = PAGE_W'($urandom);
			lo = USAGE_W'($urandom);
			v1 = $urandom;
			v2 = $urandom;
			if (choice < 5) begin
				push_item(CMD_W'($urandom_range(0, 15)), $urandom,
					BYTES_W'($urandom_range(0, 7)), PAGE_W'($urandom));
			end else if (lst == KIND_USAGE) begin
				if (choice < 50) begin
					push_usage_bound(TAG_USAGE, pg, lo);
				end else if (choice < 90) begin
					hi = USAGE_W'($urandom_range(lo, 16'hFFFF));
					push_usage_pair(pg, lo, hi);
				end else begin
					case ($urandom_range(0, 2))
						0: push_usage_bound($urandom_range(0, 1) ? TAG_UMAX : TAG_UMIN, pg, lo);
						1: begin
							push_usage_bound(TAG_UMIN, pg, lo);
							push_usage_bound(TAG_UMAX, pg ^ PAGE_W'($urandom_range(1, 65535)),
								USAGE_W'($urandom));
						end
						default: begin
							lo = USAGE_W'($urandom_range(1, 65535));
							hi = USAGE_W'($urandom_range(0, lo - 1));
							push_usage_pair(pg, lo, hi);
						end
					endcase
				end
			end else begin
				tone = (lst == KIND_DESIG) ? TAG_DESIG : TAG_STRING;
				tmin = (lst == KIND_DESIG) ? TAG_DMIN : TAG_SMIN;
				tmax = (lst == KIND_DESIG) ? TAG_DMAX : TAG_SMAX;
				if (choice < 50) begin
					push_item(tone, v1, BYTES_W'($urandom_range(0, 7)), pg);
				end else if (choice < 95) begin
					if ($urandom_range(0, 1) == 0) begin
						push_item(tmin, v1, BYTES_W'($urandom_range(0, 7)), pg);
						push_item(tmax, v2, BYTES_W'($urandom_range(0, 7)), PAGE_W'($urandom));
					end else begin
						push_item(tmax, v2, BYTES_W'($urandom_range(0, 7)), pg);
						push_item(tmin, v1, BYTES_W'($urandom_range(0, 7)), PAGE_W'($urandom));
					end
				end else begin
					push_item($urandom_range(0, 1) ? tmax : tmin, v1,
						BYTES_W'($urandom_range(0, 7)), pg);
				end
			end
			if (!paused_once && n_pushed > 350) begin
				paused_once = 1'b1;
				drain_results();
			end
			while (pending_items.size() > 8) @(posedge clk);
		end

		while (pending_items.size() != 0) @(posedge clk);
		drain_results();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
